@@ design/satdc_pkg.sv @@
// ----------------------------------------------------------------------------
// satdc_pkg: shared types and constants for the auto-tare drift compensator
// Command codes, configuration register indexes and the tracking state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package satdc_pkg;

    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int LIMIT_W   = 10;
    localparam int COUNT_W   = 8;

    localparam logic [CMD_W-1:0] CMD_IDLE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SYNC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ANCHOR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT = 2'd1;

    localparam logic [LIMIT_W-1:0] DRIFT_LIMIT_RST  = 10'd2;
    localparam logic [COUNT_W-1:0] STABLE_COUNT_RST = 8'd5;
    localparam logic [COUNT_W-1:0] QUIET_SAT        = 8'hFF;

    typedef struct packed {
        logic               anchored;
        logic               pending;
        logic               prev_known;
        logic               error_seen;
        logic               last_error;
        logic [COUNT_W-1:0] quiet_count;
    } track_t;

endpackage

@@ design/satdc_if.sv @@
// ----------------------------------------------------------------------------
// satdc_if: handshake channels of the auto-tare drift compensator
// Sample request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface satdc_item_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic [satdc_pkg::CMD_W-1:0]         cmd;
    logic signed [WEIGHT_BITS-1:0]       load_grams;
    logic                                reading_ok;
    logic                                dispense_busy;
    logic                                bowl_error_active;

    modport source (
        output valid, cmd, load_grams, reading_ok, dispense_busy, bowl_error_active,
        input  ready
    );
    modport sink (
        input  valid, cmd, load_grams, reading_ok, dispense_busy, bowl_error_active,
        output ready
    );
endinterface

interface satdc_result_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] corrected_grams;
    logic                          calibration_pending;
    logic                          anchor_valid;
    logic signed [WEIGHT_BITS-1:0] anchor_grams;
    logic signed [WEIGHT_BITS:0]   offset_grams;

    modport source (
        output valid, corrected_grams, calibration_pending, anchor_valid,
               anchor_grams, offset_grams,
        input  ready
    );
    modport sink (
        input  valid, corrected_grams, calibration_pending, anchor_valid,
               anchor_grams, offset_grams,
        output ready
    );
endinterface

interface satdc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [satdc_pkg::CFG_IDX_W-1:0]     index;
    logic [satdc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/satdc_core.sv @@
// ----------------------------------------------------------------------------
// satdc_core: next-state and result logic for one sample request
// Quiet detection, anchor capture, bowl error edges and saturated correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module satdc_core #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic [satdc_pkg::CMD_W-1:0]   cmd,
    input  logic signed [WEIGHT_BITS-1:0] raw,
    input  logic                          reading_ok,
    input  logic                          busy,
    input  logic                          error_active,
    input  logic [satdc_pkg::LIMIT_W-1:0] drift_limit,
    input  logic [satdc_pkg::COUNT_W-1:0] stable_count,
    input  satdc_pkg::track_t             track,
    input  logic signed [WEIGHT_BITS-1:0] anchor,
    input  logic signed [WEIGHT_BITS:0]   offset,
    input  logic signed [WEIGHT_BITS-1:0] prev_raw,
    output satdc_pkg::track_t             track_next,
    output logic signed [WEIGHT_BITS-1:0] anchor_next,
    output logic signed [WEIGHT_BITS:0]   offset_next,
    output logic signed [WEIGHT_BITS-1:0] prev_raw_next,
    output logic signed [WEIGHT_BITS-1:0] corrected
);

    localparam int OFF_W = WEIGHT_BITS + 1;
    localparam int SUM_W = WEIGHT_BITS + 2;
    localparam int CMP_W = (OFF_W > satdc_pkg::LIMIT_W) ? OFF_W : satdc_pkg::LIMIT_W;

    logic signed [OFF_W-1:0]         diff;
    logic [OFF_W-1:0]                abs_diff;
    logic                            quiet;
    logic [satdc_pkg::COUNT_W-1:0]   count_inc;
    logic signed [SUM_W-1:0]         sum;

    assign diff     = OFF_W'(raw) - OFF_W'(prev_raw);
    assign abs_diff = diff[OFF_W-1] ? OFF_W'(-diff) : OFF_W'(diff);
    assign quiet    = !track.prev_known
                   || (CMP_W'(abs_diff) <= CMP_W'(drift_limit));
    assign count_inc = (track.quiet_count != satdc_pkg::QUIET_SAT)
                     ? satdc_pkg::COUNT_W'(track.quiet_count + 1'b1)
                     : track.quiet_count;

    always_comb
    begin
        track_next    = track;
        anchor_next   = anchor;
        offset_next   = offset;
        prev_raw_next = prev_raw;

        case (cmd)
            satdc_pkg::CMD_IDLE:
            begin
                if (!busy)
                begin
                    if (!reading_ok)
                    begin
                        track_next.prev_known  = 1'b0;
                        track_next.quiet_count = '0;
                    end
                    else if (track.pending)
                    begin
                        if (quiet && (count_inc >= stable_count))
                        begin
                            anchor_next            = raw;
                            offset_next            = '0;
                            track_next.anchored    = 1'b1;
                            track_next.pending     = 1'b0;
                            track_next.prev_known  = 1'b0;
                            track_next.quiet_count = '0;
                        end
                        else
                        begin
                            track_next.quiet_count = quiet ? count_inc : '0;
                            track_next.prev_known  = 1'b1;
                            prev_raw_next          = raw;
                        end
                    end
                    else
                    begin
                        // anchored: a quiet sample after a tracked one retunes the offset
                        if (track.anchored && track.prev_known && quiet)
                        begin
                            offset_next = OFF_W'(anchor) - OFF_W'(raw);
                        end
                        track_next.prev_known = 1'b1;
                        prev_raw_next         = raw;
                    end
                end
            end
            satdc_pkg::CMD_SYNC:
            begin
                track_next.error_seen = 1'b1;
                track_next.last_error = error_active;
                if ((!track.error_seen || !track.last_error) && error_active)
                begin
                    // bowl removed: drop the anchor and restart calibration
                    track_next.anchored    = 1'b0;
                    track_next.pending     = 1'b1;
                    offset_next            = '0;
                    track_next.prev_known  = 1'b0;
                    track_next.quiet_count = '0;
                end
                else if (track.error_seen && track.last_error && !error_active)
                begin
                    track_next.prev_known  = 1'b0;
                    track_next.quiet_count = '0;
                end
            end
            satdc_pkg::CMD_ANCHOR:
            begin
                anchor_next            = raw;
                offset_next            = '0;
                track_next.anchored    = 1'b1;
                track_next.pending     = 1'b0;
                track_next.prev_known  = 1'b0;
                track_next.quiet_count = '0;
            end
            default:
            begin
                track_next = track;
            end
        endcase
    end

    assign sum = SUM_W'(raw) + SUM_W'(offset_next);

    always_comb
    begin
        corrected = raw;
        if (reading_ok && track_next.anchored && !track_next.pending)
        begin
            if (sum[SUM_W-1:WEIGHT_BITS-1] == '0 || sum[SUM_W-1:WEIGHT_BITS-1] == '1)
            begin
                corrected = sum[WEIGHT_BITS-1:0];
            end
            else if (sum[SUM_W-1])
            begin
                corrected = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
            end
            else
            begin
                corrected = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
            end
        end
    end

endmodule

@@ design/scale_auto_tare_drift_comp_unit.sv @@
// ----------------------------------------------------------------------------
// scale_auto_tare_drift_comp_unit: load-cell auto-tare with drift compensation
// A request waits in the input stage; its state and result are then registered.
// Throughput: one request per cycle while results are taken; one state update each.
// Reset clears handshakes, tracking and anchor; registers return to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scale_auto_tare_drift_comp_unit #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    satdc_item_if.sink     item,
    satdc_result_if.source result,
    satdc_cfg_if.sink      cfg
);

    // configuration registers
    logic [satdc_pkg::LIMIT_W-1:0]   drift_limit_reg;
    logic [satdc_pkg::COUNT_W-1:0]   stable_count_reg;

    // input stage
    logic                            s1_valid_reg;
    logic [satdc_pkg::CMD_W-1:0]     s1_cmd_reg;
    logic signed [WEIGHT_BITS-1:0]   s1_raw_reg;
    logic                            s1_reading_ok_reg;
    logic                            s1_busy_reg;
    logic                            s1_error_reg;
    logic                            s1_advance;
    logic                            s1_fire;

    // block state
    satdc_pkg::track_t               track_reg;
    satdc_pkg::track_t               track_next;
    logic signed [WEIGHT_BITS-1:0]   anchor_reg;
    logic signed [WEIGHT_BITS-1:0]   anchor_next;
    logic signed [WEIGHT_BITS:0]     offset_reg;
    logic signed [WEIGHT_BITS:0]     offset_next;
    logic signed [WEIGHT_BITS-1:0]   prev_raw_reg;
    logic signed [WEIGHT_BITS-1:0]   prev_raw_next;
    logic signed [WEIGHT_BITS-1:0]   corrected;

    // result stage
    logic                            out_valid_reg;
    logic signed [WEIGHT_BITS-1:0]   out_corrected_reg;
    logic                            out_pending_reg;
    logic                            out_anchored_reg;
    logic signed [WEIGHT_BITS-1:0]   out_anchor_reg;
    logic signed [WEIGHT_BITS:0]     out_offset_reg;

    assign cfg.ready  = 1'b1;
    assign s1_advance = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign item.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_limit_reg  <= satdc_pkg::DRIFT_LIMIT_RST;
            stable_count_reg <= satdc_pkg::STABLE_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                satdc_pkg::REG_DRIFT_LIMIT:
                begin
                    drift_limit_reg <= cfg.data[satdc_pkg::LIMIT_W-1:0];
                end
                satdc_pkg::REG_STABLE_COUNT:
                begin
                    stable_count_reg <= cfg.data[satdc_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    drift_limit_reg <= drift_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_cmd_reg        <= item.cmd;
            s1_raw_reg        <= item.load_grams;
            s1_reading_ok_reg <= item.reading_ok;
            s1_busy_reg       <= item.dispense_busy;
            s1_error_reg      <= item.bowl_error_active;
        end
    end

    satdc_core #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .cmd           (s1_cmd_reg),
        .raw           (s1_raw_reg),
        .reading_ok    (s1_reading_ok_reg),
        .busy          (s1_busy_reg),
        .error_active  (s1_error_reg),
        .drift_limit   (drift_limit_reg),
        .stable_count  (stable_count_reg),
        .track         (track_reg),
        .anchor        (anchor_reg),
        .offset        (offset_reg),
        .prev_raw      (prev_raw_reg),
        .track_next    (track_next),
        .anchor_next   (anchor_next),
        .offset_next   (offset_next),
        .prev_raw_next (prev_raw_next),
        .corrected     (corrected)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg  <= '{anchored: 1'b0, pending: 1'b1, prev_known: 1'b0,
                            error_seen: 1'b0, last_error: 1'b0, quiet_count: '0};
            anchor_reg <= '0;
            offset_reg <= '0;
        end
        else if (s1_fire)
        begin
            track_reg  <= track_next;
            anchor_reg <= anchor_next;
            offset_reg <= offset_next;
        end
    end

    // last raw reading is only read while prev_known is set
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            prev_raw_reg <= prev_raw_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_corrected_reg <= corrected;
            out_pending_reg   <= track_next.pending;
            out_anchored_reg  <= track_next.anchored;
            out_anchor_reg    <= anchor_next;
            out_offset_reg    <= offset_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.corrected_grams     = out_corrected_reg;
    assign result.calibration_pending = out_pending_reg;
    assign result.anchor_valid        = out_anchored_reg;
    assign result.anchor_grams        = out_anchor_reg;
    assign result.offset_grams        = out_offset_reg;

    // exactly one of calibrating and anchored holds at all times
    assert property (@(posedge clk) disable iff (!rst_n)
        track_reg.pending != track_reg.anchored)
        else $error("pending and anchored flags disagree");

    // a drift offset exists only while anchored
    assert property (@(posedge clk) disable iff (!rst_n)
        track_reg.anchored || (offset_reg == '0))
        else $error("nonzero offset without an anchor");

    // the quiet counter runs only during calibration
    assert property (@(posedge clk) disable iff (!rst_n)
        !track_reg.pending |-> (track_reg.quiet_count == '0))
        else $error("quiet count left behind after anchoring");

    // a held input stage may only be overwritten when it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && s1_valid_reg) |-> s1_advance)
        else $error("input stage overwritten while stalled");

endmodule
